// ----- hw/rtl/qped_pkg.sv -----
package qped_pkg;

   localparam int MAX_BEATS = 4;
   localparam int BEAT_IDX_W = 2;
   localparam int BEAT_CNT_W = 3;

   typedef logic [1:0] kind_type;

   localparam kind_type KIND_BYTE    = 2'd0;
   localparam kind_type KIND_FOUND   = 2'd1;
   localparam kind_type KIND_MISSING = 2'd2;

   localparam logic [7:0] CHAR_QUESTION = 8'h3F;
   localparam logic [7:0] CHAR_EQUAL    = 8'h3D;
   localparam logic [7:0] CHAR_AMP      = 8'h26;
   localparam logic [7:0] CHAR_PLUS     = 8'h2B;
   localparam logic [7:0] CHAR_PERCENT  = 8'h25;
   localparam logic [7:0] CHAR_SPACE    = 8'h20;
   localparam logic [7:0] CHAR_CR       = 8'h0D;
   localparam logic [7:0] CHAR_LF       = 8'h0A;
   localparam logic [7:0] CHAR_NUL      = 8'h00;

   typedef enum logic [1:0] {
      REG_KEY_TEXT    = 2'd0,
      REG_KEY_LENGTH  = 2'd1,
      REG_VALUE_LIMIT = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_request;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      kind_type   kind;
   } rsp_type;

   // all beats caused by one request byte
   typedef struct packed {
      logic [BEAT_CNT_W-1:0]  count;
      rsp_type [MAX_BEATS-1:0] beat;
   } group_type;

   typedef struct packed {
      logic [63:0] key_text;
      logic [3:0]  key_length;
      logic [7:0]  value_limit;
   } cfg_type;

endpackage

// ----- hw/rtl/qped_front.sv -----
module qped_front #(
   parameter int KEY_MAX_BYTES = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  qped_pkg::cfg_type  cfg,
   input  qped_pkg::req_type  req_payload,
   input  logic               accept,
   output qped_pkg::group_type group_out,
   output logic               push
);

   localparam logic [2:0] PH_SEEK  = 3'd0;
   localparam logic [2:0] PH_MATCH = 3'd1;
   localparam logic [2:0] PH_SKIP  = 3'd2;
   localparam logic [2:0] PH_VALUE = 3'd3;
   localparam logic [2:0] PH_DONE  = 3'd4;

   localparam logic [1:0] ESC_NONE = 2'd0;
   localparam logic [1:0] ESC_PCT  = 2'd1;
   localparam logic [1:0] ESC_HEX  = 2'd2;

   localparam logic [3:0] KEY_MAX = 4'(KEY_MAX_BYTES);

   logic [2:0] phase_ff, phase_in;
   logic [3:0] match_ff, match_in;
   logic [7:0] raw_ff, raw_in;
   logic [1:0] esc_ff, esc_in;
   logic [7:0] held_ff, held_in;

   function automatic logic hex_ok(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
             (c >= 8'h61 && c <= 8'h66);
   endfunction

   function automatic logic [3:0] hex_val(input logic [7:0] c);
      logic [7:0] v;
      v = 8'h00;
      if (c >= 8'h30 && c <= 8'h39) v = c - 8'h30;
      else if (c >= 8'h41 && c <= 8'h46) v = c - 8'h37;
      else if (c >= 8'h61 && c <= 8'h66) v = c - 8'h57;
      return v[3:0];
   endfunction

   function automatic qped_pkg::group_type add_beat(input qped_pkg::group_type g,
                                                    input logic [7:0] b,
                                                    input qped_pkg::kind_type k);
      qped_pkg::group_type r;
      r = g;
      r.beat[g.count[qped_pkg::BEAT_IDX_W-1:0]] = '{out_byte: b, kind: k};
      r.count = g.count + 1'b1;
      return r;
   endfunction

   always_comb begin
      logic [7:0] b;
      logic [3:0] kl;
      logic       is_end;
      logic [7:0] key_char;
      qped_pkg::group_type g;
      b = req_payload.in_byte;
      kl = (cfg.key_length > KEY_MAX) ? KEY_MAX : cfg.key_length;
      is_end = (b == qped_pkg::CHAR_NUL) || (b == qped_pkg::CHAR_SPACE) ||
               (b == qped_pkg::CHAR_CR) || (b == qped_pkg::CHAR_LF);
      key_char = cfg.key_text[{match_ff[2:0], 3'b000} +: 8];
      g = '0;
      phase_in = phase_ff;
      match_in = match_ff;
      raw_in = raw_ff;
      esc_in = esc_ff;
      held_in = held_ff;

      unique case (phase_ff)
         PH_SEEK: begin
            if (b == qped_pkg::CHAR_QUESTION) begin
               phase_in = PH_MATCH;
               match_in = 4'd0;
            end else if (b == qped_pkg::CHAR_NUL) begin
               g = add_beat(g, 8'h00, qped_pkg::KIND_MISSING);
               phase_in = PH_DONE;
            end
         end
         PH_MATCH: begin
            priority if (is_end) begin
               g = add_beat(g, 8'h00, qped_pkg::KIND_MISSING);
               phase_in = PH_DONE;
            end else if (b == qped_pkg::CHAR_AMP) begin
               match_in = 4'd0;
            end else if (match_ff < kl && b == key_char) begin
               match_in = match_ff + 4'd1;
            end else if (match_ff >= kl && b == qped_pkg::CHAR_EQUAL) begin
               phase_in = PH_VALUE;
               raw_in = 8'd0;
               esc_in = ESC_NONE;
            end else begin
               phase_in = PH_SKIP;
            end
         end
         PH_SKIP: begin
            if (is_end) begin
               g = add_beat(g, 8'h00, qped_pkg::KIND_MISSING);
               phase_in = PH_DONE;
            end else if (b == qped_pkg::CHAR_AMP) begin
               phase_in = PH_MATCH;
               match_in = 4'd0;
            end
         end
         PH_VALUE: begin
            if (is_end || b == qped_pkg::CHAR_AMP) begin
               // flush a truncated escape, then mark found
               if (esc_ff == ESC_PCT) begin
                  g = add_beat(g, qped_pkg::CHAR_PERCENT, qped_pkg::KIND_BYTE);
               end else if (esc_ff == ESC_HEX) begin
                  g = add_beat(g, qped_pkg::CHAR_PERCENT, qped_pkg::KIND_BYTE);
                  g = add_beat(g, held_ff, qped_pkg::KIND_BYTE);
               end
               esc_in = ESC_NONE;
               phase_in = PH_DONE;
               g = add_beat(g, 8'h00, qped_pkg::KIND_FOUND);
            end else if (raw_ff < cfg.value_limit) begin
               raw_in = raw_ff + 8'd1;
               if (esc_ff == ESC_PCT && hex_ok(b)) begin
                  esc_in = ESC_HEX;
                  held_in = b;
               end else if (esc_ff == ESC_HEX && hex_ok(b)) begin
                  g = add_beat(g, {hex_val(held_ff), hex_val(b)}, qped_pkg::KIND_BYTE);
                  esc_in = ESC_NONE;
               end else begin
                  if (esc_ff == ESC_PCT) begin
                     g = add_beat(g, qped_pkg::CHAR_PERCENT, qped_pkg::KIND_BYTE);
                  end else if (esc_ff == ESC_HEX) begin
                     g = add_beat(g, qped_pkg::CHAR_PERCENT, qped_pkg::KIND_BYTE);
                     g = add_beat(g, held_ff, qped_pkg::KIND_BYTE);
                  end
                  esc_in = ESC_NONE;
                  if (b == qped_pkg::CHAR_PERCENT) begin
                     esc_in = ESC_PCT;
                  end else if (b == qped_pkg::CHAR_PLUS) begin
                     g = add_beat(g, qped_pkg::CHAR_SPACE, qped_pkg::KIND_BYTE);
                  end else begin
                     g = add_beat(g, b, qped_pkg::KIND_BYTE);
                  end
               end
            end
         end
         default: begin
         end
      endcase

      // last byte closes out the request as if a zero byte followed
      if (req_payload.end_of_request) begin
         if (phase_in == PH_VALUE) begin
            if (esc_in == ESC_PCT) begin
               g = add_beat(g, qped_pkg::CHAR_PERCENT, qped_pkg::KIND_BYTE);
            end else if (esc_in == ESC_HEX) begin
               g = add_beat(g, qped_pkg::CHAR_PERCENT, qped_pkg::KIND_BYTE);
               g = add_beat(g, held_in, qped_pkg::KIND_BYTE);
            end
            g = add_beat(g, 8'h00, qped_pkg::KIND_FOUND);
         end else if (phase_in == PH_SEEK || phase_in == PH_MATCH ||
                      phase_in == PH_SKIP) begin
            g = add_beat(g, 8'h00, qped_pkg::KIND_MISSING);
         end
         phase_in = PH_SEEK;
         match_in = 4'd0;
         raw_in = 8'd0;
         esc_in = ESC_NONE;
         held_in = 8'd0;
      end

      group_out = g;
   end

   assign push = accept && (group_out.count != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SEEK;
         match_ff <= 4'd0;
         raw_ff <= 8'd0;
         esc_ff <= ESC_NONE;
         held_ff <= 8'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         match_ff <= match_in;
         raw_ff <= raw_in;
         esc_ff <= esc_in;
         held_ff <= held_in;
      end
   end

endmodule

// ----- hw/rtl/qped_queue.sv -----
module qped_queue #(
   parameter int DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  qped_pkg::group_type push_data,
   input  logic                pop,
   output qped_pkg::group_type head,
   output logic                empty,
   output logic                full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   qped_pkg::group_type store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign head = store_ff[rd_ptr_ff];
   assign empty = (count_ff == '0);
   assign full = (count_ff == FULL_CNT);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) store_ff[wr_ptr_ff] <= push_data;
   end

endmodule

// ----- hw/rtl/qped_back.sv -----
module qped_back (
   input  logic                clock,
   input  logic                reset,
   input  qped_pkg::group_type head,
   input  logic                empty,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output qped_pkg::rsp_type   rsp_payload
);

   qped_pkg::group_type cur_ff;
   logic [qped_pkg::BEAT_IDX_W-1:0] pos_ff;
   logic busy_ff;
   logic beat_done;
   logic last_beat;

   assign rsp_valid = busy_ff;
   assign rsp_payload = cur_ff.beat[pos_ff];
   assign beat_done = busy_ff && rsp_ready;
   assign last_beat = beat_done &&
                      (({1'b0, pos_ff} + qped_pkg::BEAT_CNT_W'(1)) == cur_ff.count);
   assign pop = (!busy_ff || last_beat) && !empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pos_ff <= '0;
      end else if (pop) begin
         busy_ff <= 1'b1;
         pos_ff <= '0;
      end else if (last_beat) begin
         busy_ff <= 1'b0;
      end else if (beat_done) begin
         // advance to the next beat of this group
         pos_ff <= pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) cur_ff <= head;
   end

endmodule

// ----- hw/rtl/query_param_extract_decode_unit.sv -----
// First result beat of a byte is registered in the group queue, then in the output
// stage. One request byte per cycle is taken while the group queue has room; results
// leave at one beat per cycle while rsp_ready is high, so a multi-beat byte holds the output.
// Queue of QUEUE_DEPTH result groups decouples the parser from the output side.
// Reset (synchronous): registers to defaults, parser before '?', queue empty.
module query_param_extract_decode_unit #(
   parameter int KEY_MAX_BYTES = 8,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  qped_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output qped_pkg::rsp_type rsp_payload,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [4:0]        paddr,
   input  logic [63:0]       pwdata,
   output logic [63:0]       prdata,
   output logic              pready
);

   qped_pkg::cfg_type cfg_ff;
   qped_pkg::group_type front_group;
   qped_pkg::group_type queue_head;
   qped_pkg::reg_index_type reg_idx;
   logic front_push;
   logic queue_pop;
   logic queue_empty;
   logic queue_full;
   logic accept;

   assign pready = 1'b1;
   assign reg_idx = qped_pkg::reg_index_type'(paddr[4:3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.key_text <= 64'd0;
         cfg_ff.key_length <= 4'd3;
         cfg_ff.value_limit <= 8'd255;
      end else if (psel && penable && pwrite) begin
         unique case (paddr[4:3])
            qped_pkg::REG_KEY_TEXT:    cfg_ff.key_text <= pwdata;
            qped_pkg::REG_KEY_LENGTH:  cfg_ff.key_length <= pwdata[3:0];
            qped_pkg::REG_VALUE_LIMIT: cfg_ff.value_limit <= pwdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         qped_pkg::REG_KEY_TEXT:    prdata = cfg_ff.key_text;
         qped_pkg::REG_KEY_LENGTH:  prdata = {60'd0, cfg_ff.key_length};
         qped_pkg::REG_VALUE_LIMIT: prdata = {56'd0, cfg_ff.value_limit};
         default:                   prdata = 64'd0;
      endcase
   end

   assign req_ready = !queue_full;
   assign accept = req_valid && req_ready;

   qped_front #(
      .KEY_MAX_BYTES(KEY_MAX_BYTES)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .req_payload(req_payload),
      .accept(accept),
      .group_out(front_group),
      .push(front_push)
   );

   qped_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push(front_push),
      .push_data(front_group),
      .pop(queue_pop),
      .head(queue_head),
      .empty(queue_empty),
      .full(queue_full)
   );

   qped_back u_back (
      .clock(clock),
      .reset(reset),
      .head(queue_head),
      .empty(queue_empty),
      .pop(queue_pop),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload)
   );

endmodule
